>>> sv/tgee_pkg.sv
// shared types and constants for the tile gutter edge extrude unit
`timescale 1ns / 1ps

package tgee_pkg;

    // register field widths
    localparam int TILE_W  = 9;
    localparam int DIM_W   = 13;
    localparam int COORD_W = 14;
    localparam int PIXEL_W = 32;

    // clamp limits of the registers
    localparam int TILE_MAX = 256;
    localparam int MAX_DIM  = 4096;

    // register reset values
    localparam logic [TILE_W-1:0] TILE_RESET  = TILE_W'(16);
    localparam logic [DIM_W-1:0]  WIDTH_RESET = DIM_W'(256);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(256);

    // source counters
    localparam int SRC_W = 12;
    localparam int INT_W = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 64;

    // register indexes
    typedef enum logic [1:0] {
        REG_TILE_SIZE    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    // write kinds emitted for one pixel, in output order
    typedef enum logic [1:0] {
        PH_SELF = 2'd0,
        PH_HORZ = 2'd1,
        PH_VERT = 2'd2,
        PH_DIAG = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_size;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } cfg_t;

    // one classified pixel
    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] vy;
        logic               hcopy;
        logic               vcopy;
        logic               frame_done;
        logic [PIXEL_W-1:0] pixel;
    } work_item_t;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> sv/tgee_front.sv
// front end: accepts pixels, tracks tile position, classifies edge copies
`timescale 1ns / 1ps

module tgee_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tgee_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tgee_pkg::PIXEL_W-1:0]  pixel_in,
    input  tgee_pkg::queue_status_t       q_status,
    output logic                          q_push,
    output tgee_pkg::work_item_t          q_item
);
    import tgee_pkg::*;

    logic [SRC_W-1:0]   src_col_reg, src_col_next;
    logic [SRC_W-1:0]   src_row_reg, src_row_next;
    logic [INT_W-1:0]   col_in_tile_reg, col_in_tile_next;
    logic [INT_W-1:0]   row_in_tile_reg, row_in_tile_next;
    logic [SRC_W-1:0]   tile_col_reg, tile_col_next;
    logic [SRC_W-1:0]   tile_row_reg, tile_row_next;

    logic [TILE_W-1:0]  t_eff;
    logic [TILE_W-1:0]  t_m1;
    logic [TILE_W-1:0]  t_p2;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [20:0]        prod_x;
    logic [20:0]        prod_y;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               col_first, col_last, row_first, row_last;
    logic               row_end, frame_done;

    // clamp the registers into their working ranges
    always_comb begin
        if (cfg.tile_size == '0) begin
            t_eff = TILE_W'(1);
        end else if (cfg.tile_size > TILE_W'(TILE_MAX)) begin
            t_eff = TILE_W'(TILE_MAX);
        end else begin
            t_eff = cfg.tile_size;
        end
        if (cfg.image_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (cfg.image_width > DIM_W'(MAX_DIM)) begin
            w_eff = DIM_W'(MAX_DIM);
        end else begin
            w_eff = cfg.image_width;
        end
        if (cfg.image_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (cfg.image_height > DIM_W'(MAX_DIM)) begin
            h_eff = DIM_W'(MAX_DIM);
        end else begin
            h_eff = cfg.image_height;
        end
    end

    assign t_m1 = t_eff - TILE_W'(1);
    assign t_p2 = t_eff + TILE_W'(2);

    // destination of the pixel inside its padded cell
    assign prod_x = 21'(tile_col_reg) * 21'(t_p2);
    assign prod_y = 21'(tile_row_reg) * 21'(t_p2);
    assign dx = prod_x[COORD_W-1:0] + COORD_W'(1) + COORD_W'(col_in_tile_reg);
    assign dy = prod_y[COORD_W-1:0] + COORD_W'(1) + COORD_W'(row_in_tile_reg);

    // edge classification, first edge wins over last edge
    assign col_first = (col_in_tile_reg == '0);
    assign row_first = (row_in_tile_reg == '0);
    assign col_last  = ({1'b0, col_in_tile_reg} == t_m1);
    assign row_last  = ({1'b0, row_in_tile_reg} == t_m1);

    assign row_end    = ({1'b0, src_col_reg} + DIM_W'(1)) >= w_eff;
    assign frame_done = row_end && (({1'b0, src_row_reg} + DIM_W'(1)) >= h_eff);

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready;

    // item pushed to the queue
    always_comb begin
        q_item            = '0;
        q_item.dx         = dx;
        q_item.dy         = dy;
        q_item.hcopy      = col_first || col_last;
        q_item.vcopy      = row_first || row_last;
        q_item.hx         = col_first ? dx - COORD_W'(1) : dx + COORD_W'(1);
        q_item.vy         = row_first ? dy - COORD_W'(1) : dy + COORD_W'(1);
        q_item.frame_done = frame_done;
        q_item.pixel      = pixel_in;
    end

    // raster and tile counters
    always_comb begin
        src_col_next     = src_col_reg;
        src_row_next     = src_row_reg;
        col_in_tile_next = col_in_tile_reg;
        row_in_tile_next = row_in_tile_reg;
        tile_col_next    = tile_col_reg;
        tile_row_next    = tile_row_reg;
        if (q_push) begin
            if (row_end) begin
                src_col_next     = '0;
                col_in_tile_next = '0;
                tile_col_next    = '0;
                if (frame_done) begin
                    src_row_next     = '0;
                    row_in_tile_next = '0;
                    tile_row_next    = '0;
                end else begin
                    src_row_next = src_row_reg + SRC_W'(1);
                    if (({1'b0, row_in_tile_reg} + TILE_W'(1)) >= t_eff) begin
                        row_in_tile_next = '0;
                        tile_row_next    = tile_row_reg + SRC_W'(1);
                    end else begin
                        row_in_tile_next = row_in_tile_reg + INT_W'(1);
                    end
                end
            end else begin
                src_col_next = src_col_reg + SRC_W'(1);
                if (({1'b0, col_in_tile_reg} + TILE_W'(1)) >= t_eff) begin
                    col_in_tile_next = '0;
                    tile_col_next    = tile_col_reg + SRC_W'(1);
                end else begin
                    col_in_tile_next = col_in_tile_reg + INT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            col_in_tile_reg <= '0;
            row_in_tile_reg <= '0;
            tile_col_reg    <= '0;
            tile_row_reg    <= '0;
        end else begin
            src_col_reg     <= src_col_next;
            src_row_reg     <= src_row_next;
            col_in_tile_reg <= col_in_tile_next;
            row_in_tile_reg <= row_in_tile_next;
            tile_col_reg    <= tile_col_next;
            tile_row_reg    <= tile_row_next;
        end
    end

endmodule

>>> sv/tgee_queue.sv
// short queue of classified pixels between front and back
`timescale 1ns / 1ps

module tgee_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  tgee_pkg::work_item_t     push_item,
    input  logic                     pop,
    output tgee_pkg::work_item_t     head_item,
    output tgee_pkg::queue_status_t  status
);
    import tgee_pkg::*;

    work_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/tgee_back.sv
// back end: expands one classified pixel into its frame-store writes
`timescale 1ns / 1ps

module tgee_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tgee_pkg::queue_status_t          q_status,
    input  tgee_pkg::work_item_t             q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tgee_pkg::COORD_W-1:0]     dest_x,
    output logic [tgee_pkg::COORD_W-1:0]     dest_y,
    output logic [tgee_pkg::PIXEL_W-1:0]     pixel_out,
    output logic                             last_write,
    output logic                             frame_end
);
    import tgee_pkg::*;

    phase_t              phase_reg, phase_next, phase_after;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [COORD_W-1:0]  dest_x_reg, dest_y_reg;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic                last_reg, frame_end_reg;
    logic                load;
    logic                done;
    logic [COORD_W-1:0]  cur_x, cur_y;

    assign load = !q_status.empty && (!m_tvalid_reg || m_tready);

    // which write follows the current one
    always_comb begin
        phase_after = PH_SELF;
        done        = 1'b1;
        case (phase_reg)
            PH_SELF: begin
                if (q_item.hcopy) begin
                    phase_after = PH_HORZ;
                    done        = 1'b0;
                end else if (q_item.vcopy) begin
                    phase_after = PH_VERT;
                    done        = 1'b0;
                end
            end
            PH_HORZ: begin
                if (q_item.vcopy) begin
                    phase_after = PH_VERT;
                    done        = 1'b0;
                end
            end
            PH_VERT: begin
                if (q_item.hcopy) begin
                    phase_after = PH_DIAG;
                    done        = 1'b0;
                end
            end
            PH_DIAG: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (load) begin
            phase_next = done ? PH_SELF : phase_after;
        end
    end

    // coordinates of the current write
    always_comb begin
        case (phase_reg)
            PH_SELF: begin
                cur_x = q_item.dx;
                cur_y = q_item.dy;
            end
            PH_HORZ: begin
                cur_x = q_item.hx;
                cur_y = q_item.dy;
            end
            PH_VERT: begin
                cur_x = q_item.dx;
                cur_y = q_item.vy;
            end
            PH_DIAG: begin
                cur_x = q_item.hx;
                cur_y = q_item.vy;
            end
            default: begin
                cur_x = q_item.dx;
                cur_y = q_item.dy;
            end
        endcase
    end

    assign q_pop = load && done;

    // output register valid
    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SELF;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            dest_x_reg    <= cur_x;
            dest_y_reg    <= cur_y;
            pixel_reg     <= q_item.pixel;
            last_reg      <= done;
            frame_end_reg <= done && q_item.frame_done;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign dest_x     = dest_x_reg;
    assign dest_y     = dest_y_reg;
    assign pixel_out  = pixel_reg;
    assign last_write = last_reg;
    assign frame_end  = frame_end_reg;

endmodule

>>> sv/tile_gutter_edge_extrude_unit.sv
// top level of the tile gutter edge extrude unit with its register port
//
// Pixels of an image arrive in raster order on the s_ stream, one RGBA word
// per transfer. For each pixel the m_ stream carries one to four frame-store
// writes into the padded image: the pixel itself, then a horizontal, a
// vertical and a diagonal copy where the pixel sits on a tile edge or corner.
// m_tlast marks the last write of a pixel, m_tuser the last write of the frame.
// Tile size and image dimensions are set over the APB port; the user must set
// them only while idle, which the block itself does not enforce. The first
// write of a pixel is written into the queue at the transfer edge, then
// loaded from the queue into the output register, which presents it.
// Throughput: one write per cycle while the receiver accepts, set by the
// single output register of the back end; an interior pixel takes one write,
// an edge pixel two, a corner pixel four. The front takes one pixel per cycle
// while the four-entry queue has room, so extra copies hold off input only
// once the queue fills. Reset clears the raster counters, empties the queue and
// restores the registers to tile 16 and a 256 by 256 image. When the receiver
// stalls the output write holds, the queue fills and s_tready drops.
`timescale 1ns / 1ps

module tile_gutter_edge_extrude_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pixel_in
    // write stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [13:0] dest_x, [27:14] dest_y, [59:28] pixel_out
    output logic        m_tlast,   // last_write
    output logic        m_tuser,   // [0] frame_end
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tgee_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    reg_index_t          reg_sel;
    logic                cfg_wr;
    logic                q_push, q_pop;
    work_item_t          push_item, head_item;
    queue_status_t       q_status;
    logic [COORD_W-1:0]  dest_x, dest_y;
    logic [PIXEL_W-1:0]  pixel_out;
    logic                last_write, frame_end;

    // register decode
    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_sel)
                REG_TILE_SIZE:    cfg_next.tile_size    = pwdata[TILE_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[DIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_size    <= TILE_RESET;
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_TILE_SIZE:    prdata = PDATA_W'(cfg_reg.tile_size);
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(cfg_reg.image_height);
            default:          prdata = '0;
        endcase
    end

    tgee_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pixel_in (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tgee_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    tgee_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .dest_x     (dest_x),
        .dest_y     (dest_y),
        .pixel_out  (pixel_out),
        .last_write (last_write),
        .frame_end  (frame_end)
    );

    // pack the write transfer
    assign m_tdata = {4'b0, pixel_out, dest_y, dest_x};
    assign m_tlast = last_write;
    assign m_tuser = frame_end;

    // frame end only rides on the last write of a pixel
    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end on a write that is not the last of its pixel");

    // a pixel's writes follow each other without a gap
    a_writes_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside the writes of one pixel");

    // the queue is only popped when it holds an entry
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // a pop always comes with a last write loaded into the output register
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid && m_tlast)
        else $error("queue popped without a last write");

endmodule
